// File: src/deadline_sorted_callout_queue_defines.svh
`ifndef DEADLINE_SORTED_CALLOUT_QUEUE_DEFINES_SVH
`define DEADLINE_SORTED_CALLOUT_QUEUE_DEFINES_SVH

// Checks clocked on clock and held off while reset is high.
`define DSCQ_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition in one cycle implies the consequent in the next.
`define DSCQ_CHECK_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// File: src/dscq_pkg.sv
`default_nettype none

package dscq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_BITS_DEF     = 8;

   localparam logic [1:0] CMD_START32 = 2'd0;
   localparam logic [1:0] CMD_START64 = 2'd1;
   localparam logic [1:0] CMD_STOP    = 2'd2;
   localparam logic [1:0] CMD_TICK    = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NOT_INIT = 2'd1;
   localparam logic [1:0] STATUS_DUP      = 2'd2;
   localparam logic [1:0] STATUS_FULL     = 2'd3;

   localparam logic [31:0] WAIT_MAX = 32'hffff_ffff;

   typedef struct packed {
      logic [63:0] deadline;
      logic [63:0] handler;
      logic [63:0] arg;
   } slot_data_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_MATCH,
      CELL_COMPARE,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        occupied;
      logic        tail;
   } cell_ctl_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        removed;
      logic        fired;
      logic [7:0]  entry;
      logic [63:0] handler;
      logic [63:0] arg;
      logic [31:0] next_wait;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/dscq_cell.sv
`default_nettype none

module dscq_cell import dscq_pkg::*; #(
   parameter int ID_BITS = ID_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctl_type        ctl,
   input  logic [ID_BITS-1:0]  req_id,
   input  slot_data_type       new_data,
   input  logic [ID_BITS-1:0]  left_id,
   input  slot_data_type       left_data,
   input  logic                left_ge,
   input  logic                left_hit,
   input  logic [ID_BITS-1:0]  right_id,
   input  slot_data_type       right_data,
   output logic [ID_BITS-1:0]  slot_id,
   output slot_data_type       slot_data,
   output logic                ge_out,
   output logic                hit_out,
   output logic                slot_match
);

   logic [ID_BITS-1:0] id_ff, id_in;
   slot_data_type      data_ff, data_in;
   logic               ge_ff, ge_in;
   logic               match_ff, match_in;

   always_comb begin
      id_in    = id_ff;
      data_in  = data_ff;
      ge_in    = ge_ff;
      match_in = match_ff;
      unique case (ctl.op)
         CELL_MATCH: begin
            match_in = ctl.occupied && (id_ff == req_id);
         end
         CELL_COMPARE: begin
            ge_in = ctl.occupied &&
                    ($signed(data_ff.deadline) >= $signed(new_data.deadline));
         end
         CELL_INSERT: begin
            // everything from the insert point on moves one cell toward the tail
            if (left_ge) begin
               id_in   = left_id;
               data_in = left_data;
            end else if (ge_ff || ctl.tail) begin
               id_in   = req_id;
               data_in = new_data;
            end
         end
         CELL_REMOVE: begin
            if (left_hit || match_ff) begin
               id_in   = right_id;
               data_in = right_data;
            end
         end
         CELL_POP: begin
            id_in   = right_id;
            data_in = right_data;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ge_ff    <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         ge_ff    <= ge_in;
         match_ff <= match_in;
      end
   end

   assign slot_id    = id_ff;
   assign slot_data  = data_ff;
   assign ge_out     = ge_ff;
   assign hit_out    = left_hit | match_ff;
   assign slot_match = match_ff;

endmodule

`default_nettype wire

// File: src/deadline_sorted_callout_queue.sv
`default_nettype none

`include "deadline_sorted_callout_queue_defines.svh"

// Sorted callout queue built as a row of QUEUE_DEPTH cells, head in cell 0.
// A command is taken when start is high and busy is low. Results come out
// on rsp_* with rsp_strobe high for one cycle each; there is no backpressure,
// so the receiver must take every beat as it comes. Start runs through capture,
// deadline add, compare in all cells and shift/insert; stop through capture,
// id match and shift; tick runs the head compare and pop once per cycle for
// each expired entry. With enabled low any command answers with one status
// beat.
module deadline_sorted_callout_queue import dscq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int ID_BITS     = ID_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_entry_id,
   input  logic signed [63:0] req_delay,
   input  logic [63:0]        req_handler_tag,
   input  logic [63:0]        req_callback_arg,
   input  logic [62:0]        req_now_time,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic               rsp_removed,
   output logic               rsp_fired,
   output logic [7:0]         rsp_fired_entry,
   output logic [63:0]        rsp_fired_handler,
   output logic [63:0]        rsp_fired_arg,
   output logic [31:0]        rsp_next_wait,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [0:0]         csr_wr_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_CMP,
      ST_APPLY,
      ST_TICK
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               enabled_ff;
   logic               rsp_strobe_ff, emit;
   rsp_type            rsp_ff, rsp_in;

   logic [1:0]         cmd_ff;
   logic [ID_BITS-1:0] id_ff;
   logic [63:0]        delay_ff;
   logic [62:0]        now_ff;
   logic [63:0]        handler_ff;
   logic [63:0]        arg_ff;
   logic [63:0]        dl_ff;

   cell_op_type        cell_op;
   slot_data_type      new_data;
   cell_ctl_type       cell_ctl   [QUEUE_DEPTH];
   logic [ID_BITS-1:0] q_id       [QUEUE_DEPTH];
   slot_data_type      q_data     [QUEUE_DEPTH];
   logic [ID_BITS-1:0] l_id       [QUEUE_DEPTH];
   slot_data_type      l_data     [QUEUE_DEPTH];
   logic [ID_BITS-1:0] r_id       [QUEUE_DEPTH];
   slot_data_type      r_data     [QUEUE_DEPTH];
   logic               l_ge       [QUEUE_DEPTH];
   logic               l_hit      [QUEUE_DEPTH];
   logic               ge_chain   [QUEUE_DEPTH];
   logic               hit_chain  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] match_vec;

   logic               hit_any, full, expired;
   logic [63:0]        now_ext, rem;
   logic [31:0]        wait_val;

   assign new_data = '{deadline: dl_ff, handler: handler_ff, arg: arg_ff};

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign cell_ctl[i] = '{op:       cell_op,
                             occupied: (CNT_W'(i) < count_ff),
                             tail:     (count_ff == CNT_W'(i))};
      if (i == 0) begin : g_head
         assign l_id[i]   = q_id[i];
         assign l_data[i] = q_data[i];
         assign l_ge[i]   = 1'b0;
         assign l_hit[i]  = 1'b0;
      end else begin : g_body
         assign l_id[i]   = q_id[i-1];
         assign l_data[i] = q_data[i-1];
         assign l_ge[i]   = ge_chain[i-1];
         assign l_hit[i]  = hit_chain[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign r_id[i]   = q_id[i];
         assign r_data[i] = q_data[i];
      end else begin : g_next
         assign r_id[i]   = q_id[i+1];
         assign r_data[i] = q_data[i+1];
      end

      dscq_cell #(
         .ID_BITS(ID_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[i]),
         .req_id     (id_ff),
         .new_data   (new_data),
         .left_id    (l_id[i]),
         .left_data  (l_data[i]),
         .left_ge    (l_ge[i]),
         .left_hit   (l_hit[i]),
         .right_id   (r_id[i]),
         .right_data (r_data[i]),
         .slot_id    (q_id[i]),
         .slot_data  (q_data[i]),
         .ge_out     (ge_chain[i]),
         .hit_out    (hit_chain[i]),
         .slot_match (match_vec[i])
      );
   end

   assign hit_any = hit_chain[QUEUE_DEPTH-1];
   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign now_ext = {1'b0, now_ff};
   assign expired = (count_ff != '0) && (q_data[0].deadline <= now_ext);
   assign rem     = q_data[0].deadline - now_ext;
   assign wait_val = (count_ff == '0) ? 32'd0 :
                     (|rem[63:32])     ? WAIT_MAX : rem[31:0];

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      emit      = 1'b0;
      cell_op   = CELL_HOLD;
      rsp_in    = '0;
      rsp_in.last = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (!enabled_ff) begin
                  emit          = 1'b1;
                  rsp_in.status = STATUS_NOT_INIT;
               end else if (req_cmd == CMD_TICK) begin
                  state_in = ST_TICK;
               end else begin
                  state_in = ST_ADD;
               end
            end
         end
         ST_ADD: begin
            cell_op  = CELL_MATCH;
            state_in = (cmd_ff == CMD_STOP) ? ST_APPLY : ST_CMP;
         end
         ST_CMP: begin
            cell_op  = CELL_COMPARE;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            emit     = 1'b1;
            state_in = ST_IDLE;
            if (cmd_ff == CMD_STOP) begin
               rsp_in.removed = hit_any;
               if (hit_any) begin
                  cell_op  = CELL_REMOVE;
                  count_in = count_ff - 1'b1;
               end
            end else if (hit_any) begin
               rsp_in.status = STATUS_DUP;
            end else if (full) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               cell_op  = CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         ST_TICK: begin
            emit = 1'b1;
            if (expired) begin
               cell_op        = CELL_POP;
               count_in       = count_ff - 1'b1;
               rsp_in.fired   = 1'b1;
               rsp_in.entry   = 8'(q_id[0]);
               rsp_in.handler = q_data[0].handler;
               rsp_in.arg     = q_data[0].arg;
               rsp_in.last    = 1'b0;
            end else begin
               rsp_in.next_wait = wait_val;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         enabled_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= emit;
         if (csr_wr_en) begin
            enabled_ff <= csr_wr_data[0];
         end
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // request capture; the deadline sum is registered separately, in ST_ADD
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         cmd_ff     <= req_cmd;
         id_ff      <= ID_BITS'(req_entry_id);
         delay_ff   <= (req_cmd == CMD_START32) ? {32'd0, req_delay[31:0]} : req_delay;
         now_ff     <= req_now_time;
         handler_ff <= req_handler_tag;
         arg_ff     <= req_callback_arg;
      end
      if (state_ff == ST_ADD) begin
         dl_ff <= now_ext + delay_ff;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_removed       = rsp_ff.removed;
   assign rsp_fired         = rsp_ff.fired;
   assign rsp_fired_entry   = rsp_ff.entry;
   assign rsp_fired_handler = rsp_ff.handler;
   assign rsp_fired_arg     = rsp_ff.arg;
   assign rsp_next_wait     = rsp_ff.next_wait;
   assign rsp_last          = rsp_ff.last;

   `DSCQ_CHECK(a_count_bound, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count past depth")
   `DSCQ_CHECK(a_unique_match, $onehot0(match_vec), "entry id queued more than once")
   `DSCQ_CHECK_NEXT(a_pop_count, cell_op == CELL_POP, count_ff == $past(count_ff) - 1'b1, "pop without count drop")
   `DSCQ_CHECK(a_fired_not_last, rsp_strobe_ff && rsp_ff.fired |-> !rsp_ff.last, "fired beat marked last")

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none

module tb_top import dscq_pkg::*; ();

   localparam int          CYCLE_LIMIT = 200000;
   localparam int          TAIL_CYCLES = 8;
   localparam logic [63:0] ALL_ONES    = '1;
   localparam logic [62:0] NOW_MAX     = '1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  id;
      logic [63:0] delay;
      logic [63:0] handler;
      logic [63:0] arg;
      logic [62:0] now;
   } callout_cmd_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [63:0] deadline;
      logic [63:0] handler;
      logic [63:0] arg;
   } callout_slot_type;

   // one directed row: optional enable write first, then reps commands with rising id
   typedef struct {
      int              csr_before;
      callout_cmd_type cmd;
      int              reps;
      bit              typed;
      rsp_type         want;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_cmd = CMD_TICK;
   logic [7:0]         req_entry_id = '0;
   logic signed [63:0] req_delay = '0;
   logic [63:0]        req_handler_tag = '0;
   logic [63:0]        req_callback_arg = '0;
   logic [62:0]        req_now_time = '0;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic               rsp_removed;
   logic               rsp_fired;
   logic [7:0]         rsp_fired_entry;
   logic [63:0]        rsp_fired_handler;
   logic [63:0]        rsp_fired_arg;
   logic [31:0]        rsp_next_wait;
   logic               rsp_last;
   logic               csr_wr_en = 1'b0;
   logic [0:0]         csr_wr_data = '0;

   // shadow copy of the queue
   callout_slot_type cq_slot[QUEUE_DEPTH_DEF];
   int               cq_count = 0;
   bit               cq_enabled = 1'b0;

   rsp_type          expected_rsp[$];
   directed_row_type directed_rows[$];
   int unsigned      fail_count = 0;
   int               cycle_count = 0;
   logic [62:0]      clock_now;
   bit               burst = 1'b0;

   deadline_sorted_callout_queue dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_entry_id      (req_entry_id),
      .req_delay         (req_delay),
      .req_handler_tag   (req_handler_tag),
      .req_callback_arg  (req_callback_arg),
      .req_now_time      (req_now_time),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_removed       (rsp_removed),
      .rsp_fired         (rsp_fired),
      .rsp_fired_entry   (rsp_fired_entry),
      .rsp_fired_handler (rsp_fired_handler),
      .rsp_fired_arg     (rsp_fired_arg),
      .rsp_next_wait     (rsp_next_wait),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   function automatic int slot_of(input logic [7:0] id);
      int hit;
      hit = -1;
      for (int i = cq_count - 1; i >= 0; i--)
         if (cq_slot[i].id == id) hit = i;
      return hit;
   endfunction

   function automatic void drop_slot(input int pos);
      for (int i = pos; i < cq_count - 1; i++) cq_slot[i] = cq_slot[i + 1];
      cq_count--;
   endfunction

   // advances the shadow queue by one command and queues the beats it should produce
   function automatic void predict_callout_results(input callout_cmd_type c);
      rsp_type     r;
      logic [63:0] span;
      logic [63:0] dl;
      int          pos;
      int          hit;
      r = '0;
      r.last = 1'b1;
      if (!cq_enabled) begin
         r.status = STATUS_NOT_INIT;
      end else if (c.cmd == CMD_START32 || c.cmd == CMD_START64) begin
         span = (c.cmd == CMD_START32) ? {32'd0, c.delay[31:0]} : c.delay;
         if (slot_of(c.id) >= 0) begin
            r.status = STATUS_DUP;
         end else if (cq_count >= QUEUE_DEPTH_DEF) begin
            r.status = STATUS_FULL;
         end else begin
            dl = {1'b0, c.now} + span;
            pos = cq_count;
            // new entry lands ahead of equal deadlines (signed order)
            for (int i = cq_count - 1; i >= 0; i--)
               if ($signed(cq_slot[i].deadline) >= $signed(dl)) pos = i;
            for (int i = cq_count; i > pos; i--) cq_slot[i] = cq_slot[i - 1];
            cq_slot[pos] = '{id: c.id, deadline: dl, handler: c.handler, arg: c.arg};
            cq_count++;
         end
      end else if (c.cmd == CMD_STOP) begin
         hit = slot_of(c.id);
         if (hit >= 0) begin
            drop_slot(hit);
            r.removed = 1'b1;
         end
      end else begin
         // expiry uses an unsigned compare, unlike insertion
         while (cq_count > 0 && cq_slot[0].deadline <= {1'b0, c.now}) begin
            expected_rsp.push_back('{status: STATUS_OK, removed: 1'b0, fired: 1'b1,
                                     entry: cq_slot[0].id, handler: cq_slot[0].handler,
                                     arg: cq_slot[0].arg, next_wait: 32'd0, last: 1'b0});
            drop_slot(0);
         end
         if (cq_count > 0) begin
            span = cq_slot[0].deadline - {1'b0, c.now};
            r.next_wait = (span > {32'd0, WAIT_MAX}) ? WAIT_MAX : span[31:0];
         end
      end
      expected_rsp.push_back(r);
   endfunction

   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (burst || pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic callout_cmd_type random_callout();
      callout_cmd_type c;
      int              pick;
      pick = $urandom_range(0, 99);
      clock_now = clock_now + 63'($urandom_range(0, 40));
      c.cmd = (pick < 22) ? CMD_START32 : (pick < 44) ? CMD_START64 :
              (pick < 64) ? CMD_STOP : CMD_TICK;
      c.id = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
      c.delay = {32'($urandom), 32'($urandom)};
      if ($urandom_range(0, 7) != 0) begin
         if (c.cmd == CMD_START64) begin
            c.delay = 64'($urandom_range(0, 400));
            if ($urandom_range(0, 5) == 0) c.delay = -c.delay;
         end else begin
            c.delay[31:0] = 32'($urandom_range(0, 400));
         end
      end
      c.handler = {32'($urandom), 32'($urandom)};
      c.arg = {32'($urandom), 32'($urandom)};
      c.now = ($urandom_range(0, 9) == 0) ? 63'({$urandom, $urandom}) : clock_now;
      return c;
   endfunction

   task automatic issue_command(input callout_cmd_type c, input bit typed,
                                input rsp_type want);
      int gap;
      start <= 1'b1;
      req_cmd <= c.cmd;
      req_entry_id <= c.id;
      req_delay <= c.delay;
      req_handler_tag <= c.handler;
      req_callback_arg <= c.arg;
      req_now_time <= c.now;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predict_callout_results(c);
      if (typed) begin
         // single-beat row: the hand-written answer replaces the predicted one
         void'(expected_rsp.pop_back());
         expected_rsp.push_back(want);
      end
      gap = idle_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_queue_idle();
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_enabled(input bit value);
      wait_queue_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cq_enabled = value;
   endtask

   task automatic add_row(input int csr_before, input logic [1:0] cmd, input logic [7:0] id,
                          input logic [63:0] delay, input logic [63:0] handler,
                          input logic [63:0] arg, input logic [62:0] now, input int reps,
                          input bit typed, input logic [1:0] status, input bit removed,
                          input logic [31:0] next_wait);
      directed_row_type row;
      row.csr_before = csr_before;
      row.cmd = '{cmd: cmd, id: id, delay: delay, handler: handler, arg: arg, now: now};
      row.reps = reps;
      row.typed = typed;
      row.want = '0;
      row.want.status = status;
      row.want.removed = removed;
      row.want.next_wait = next_wait;
      row.want.last = 1'b1;
      directed_rows.push_back(row);
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         got = '{status: rsp_status, removed: rsp_removed, fired: rsp_fired,
                 entry: rsp_fired_entry, handler: rsp_fired_handler, arg: rsp_fired_arg,
                 next_wait: rsp_next_wait, last: rsp_last};
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected result beat: expected none, got %h", $time, got);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("status", 64'(want.status), 64'(got.status));
            check_field("removed", 64'(want.removed), 64'(got.removed));
            check_field("fired", 64'(want.fired), 64'(got.fired));
            check_field("fired_entry", 64'(want.entry), 64'(got.entry));
            check_field("fired_handler", want.handler, got.handler);
            check_field("fired_arg", want.arg, got.arg);
            check_field("next_wait", 64'(want.next_wait), 64'(got.next_wait));
            check_field("last", 64'(want.last), 64'(got.last));
         end
      end
   end

   initial begin
      callout_cmd_type c;
      int              phase_items[3];
      bit              phase_enabled[3];
      phase_items = '{50, 10, 66};
      phase_enabled = '{1'b1, 1'b0, 1'b1};
      clock_now = 63'({$urandom, $urandom});

      // queue disabled out of reset
      add_row(-1, CMD_START32, 8'd5, 64'd10, '0, '0, 63'd0, 1, 1, STATUS_NOT_INIT, 0, 0);
      add_row(-1, CMD_STOP, 8'd5, '0, '0, '0, 63'd0, 1, 1, STATUS_NOT_INIT, 0, 0);
      add_row(-1, CMD_TICK, 8'd0, '0, '0, '0, NOW_MAX, 1, 1, STATUS_NOT_INIT, 0, 0);
      add_row(1, CMD_TICK, 8'd0, '0, '0, '0, 63'd0, 1, 1, STATUS_OK, 0, 0);
      // largest sum turns negative and sorts to the head
      add_row(-1, CMD_START64, 8'hff, 64'h7fff_ffff_ffff_ffff, ALL_ONES, '0, NOW_MAX,
              1, 0, STATUS_OK, 0, 0);
      // delay of -1 wraps the deadline around to now - 1
      add_row(-1, CMD_START64, 8'd1, ALL_ONES, '0, ALL_ONES, 63'd5, 1, 0, STATUS_OK, 0, 0);
      // short form drops the upper half of the delay
      add_row(-1, CMD_START32, 8'd2, 64'hffff_ffff_0000_0032, '0, ALL_ONES, 63'd0,
              1, 0, STATUS_OK, 0, 0);
      add_row(-1, CMD_START64, 8'd3, 64'd50, ALL_ONES, '0, 63'd0, 1, 0, STATUS_OK, 0, 0);
      add_row(-1, CMD_START32, 8'd2, 64'd7, '0, '0, 63'd0, 1, 1, STATUS_DUP, 0, 0);
      add_row(-1, CMD_STOP, 8'd200, '0, '0, '0, 63'd0, 1, 1, STATUS_OK, 0, 0);
      add_row(-1, CMD_STOP, 8'd1, '0, '0, '0, 63'd0, 1, 1, STATUS_OK, 1, 0);
      add_row(-1, CMD_TICK, 8'd0, '0, '0, '0, 63'd49, 1, 0, STATUS_OK, 0, 0);
      add_row(-1, CMD_STOP, 8'hff, '0, '0, '0, 63'd0, 1, 1, STATUS_OK, 1, 0);
      add_row(-1, CMD_TICK, 8'd0, '0, '0, '0, 63'd60, 1, 0, STATUS_OK, 0, 0);
      add_row(-1, CMD_START32, 8'd0, 64'hffff_ffff, 64'h1234, 64'h5678, 63'd0,
              1, 0, STATUS_OK, 0, 0);
      // fill the rest with one shared deadline
      add_row(-1, CMD_START64, 8'd16, 64'd1000, 64'hdead_0000, 64'hbeef, 63'd0,
              QUEUE_DEPTH_DEF - 1, 0, STATUS_OK, 0, 0);
      add_row(-1, CMD_START32, 8'd0, 64'd3, '0, '0, 63'd0, 1, 1, STATUS_DUP, 0, 0);
      add_row(-1, CMD_START32, 8'd99, 64'd3, '0, '0, 63'd0, 1, 1, STATUS_FULL, 0, 0);
      add_row(-1, CMD_TICK, 8'd0, '0, '0, '0, NOW_MAX, 1, 0, STATUS_OK, 0, 0);
      add_row(0, CMD_START32, 8'd7, 64'd1, '0, '0, 63'd0, 1, 1, STATUS_NOT_INIT, 0, 0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].csr_before >= 0)
            write_enabled(directed_rows[r].csr_before[0]);
         for (int n = 0; n < directed_rows[r].reps; n++) begin
            c = directed_rows[r].cmd;
            c.id = c.id + 8'(n);
            issue_command(c, directed_rows[r].typed, directed_rows[r].want);
         end
      end

      for (int p = 0; p < 3; p++) begin
         write_enabled(phase_enabled[p]);
         for (int n = 0; n < phase_items[p]; n++) begin
            if (n % 16 == 0) burst = ($urandom_range(0, 3) == 0);
            if ((p == 2 && n == 45) || $urandom_range(0, 39) == 0) wait_queue_idle();
            issue_command(random_callout(), 1'b0, '0);
         end
      end

      wait_queue_idle();
      if (fail_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: deadline_sorted_callout_queue.f
+incdir+src
src/dscq_pkg.sv
src/dscq_cell.sv
src/deadline_sorted_callout_queue.sv
sim/tb_top.sv
